/* rtl/ss_pkg.sv */
// ----------------------------------------------------------------------------
// ss_pkg
// Shared types and constants for the series statistics block.
// ----------------------------------------------------------------------------
package ss_pkg;

    localparam int SAMPLE_W          = 32;
    localparam int DEF_MAX_SAMPLES   = 1024;
    localparam int DEF_FRACTION_BITS = 16;
    localparam int THR_W             = 31;
    localparam logic [THR_W-1:0] THR_RESET = 31'd6554;
    localparam int COUNT_OUT_W       = 11;
    localparam int PCT_SCALE         = 100;
    localparam int QUEUE_DEPTH       = 2;

    // job fields sized for the largest supported series
    localparam int JOB_CNT_W = 17;
    localparam int JOB_SUM_W = 48;

    typedef enum logic [1:0] {
        TREND_FLAT = 2'd0,
        TREND_UP   = 2'd1,
        TREND_DOWN = 2'd2
    } trend_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEAN,
        ST_PCT,
        ST_PASS,
        ST_VAR,
        ST_ROOT,
        ST_OUT
    } back_state_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] minimum;
        logic signed [SAMPLE_W-1:0] maximum;
        logic signed [SAMPLE_W-1:0] mean;
        logic signed [SAMPLE_W-1:0] change_pct;
        logic [SAMPLE_W-1:0]        volatility;
        trend_t                     trend;
        logic [COUNT_OUT_W-1:0]     sample_count;
        logic                       overflowed;
    } out_item_t;

    typedef struct packed {
        logic                        bank;
        logic [JOB_CNT_W-1:0]        count;
        logic signed [JOB_SUM_W-1:0] sum;
        logic signed [SAMPLE_W-1:0]  minimum;
        logic signed [SAMPLE_W-1:0]  maximum;
        logic signed [SAMPLE_W-1:0]  first;
        logic signed [SAMPLE_W-1:0]  final_value;
        logic                        dropped;
    } job_t;

endpackage

/* rtl/ss_ram.sv */
// ----------------------------------------------------------------------------
// ss_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ss_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 2048,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

/* rtl/ss_front.sv */
// ----------------------------------------------------------------------------
// ss_front
// Sample intake: stores samples, keeps running sum, min, max, first and last
// stored values, and queues one job per series.
// ----------------------------------------------------------------------------
module ss_front import ss_pkg::*; #(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    localparam int IDX_W = $clog2(MAX_SAMPLES),
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1),
    localparam int SUM_W = SAMPLE_W + IDX_W
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_data,
    output logic               wr_en,
    output logic [IDX_W:0]     wr_addr,
    output logic [SAMPLE_W-1:0] wr_data,
    output logic               job_push,
    output job_t               job,
    input  logic               job_release
);

    logic [CNT_W-1:0]           count_reg, count_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic signed [SAMPLE_W-1:0] min_reg, min_next;
    logic signed [SAMPLE_W-1:0] max_reg, max_next;
    logic signed [SAMPLE_W-1:0] first_reg, first_next;
    logic signed [SAMPLE_W-1:0] final_reg, final_next;
    logic                       dropped_reg, dropped_next;
    logic                       bank_reg;
    logic [1:0]                 pending_reg;
    logic                       accept, room;

    assign s_ready = (pending_reg != 2'd2);
    assign accept  = s_valid && s_ready;
    assign room    = (count_reg < CNT_W'(MAX_SAMPLES));

    assign wr_en   = accept && room;
    assign wr_addr = {bank_reg, count_reg[IDX_W-1:0]};
    assign wr_data = s_data.sample;

    always_comb begin
        count_next   = count_reg;
        sum_next     = sum_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        first_next   = first_reg;
        final_next   = final_reg;
        dropped_next = dropped_reg;
        if (room) begin
            count_next = count_reg + 1'b1;
            sum_next   = sum_reg + SUM_W'(s_data.sample);
            final_next = s_data.sample;
            if (count_reg == '0) begin
                first_next = s_data.sample;
            end
            if (s_data.sample < min_reg) begin
                min_next = s_data.sample;
            end
            if (s_data.sample > max_reg) begin
                max_next = s_data.sample;
            end
        end else begin
            dropped_next = 1'b1;
        end
    end

    assign job_push        = accept && s_data.last;
    assign job.bank        = bank_reg;
    assign job.count       = JOB_CNT_W'(count_next);
    assign job.sum         = JOB_SUM_W'(sum_next);
    assign job.minimum     = min_next;
    assign job.maximum     = max_next;
    assign job.first       = first_next;
    assign job.final_value = final_next;
    assign job.dropped     = dropped_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || job_push) begin
            count_reg   <= '0;
            sum_reg     <= '0;
            min_reg     <= {1'b0, {(SAMPLE_W-1){1'b1}}};
            max_reg     <= {1'b1, {(SAMPLE_W-1){1'b0}}};
            first_reg   <= '0;
            dropped_reg <= 1'b0;
        end else if (accept) begin
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
            first_reg   <= first_next;
            dropped_reg <= dropped_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            final_reg <= final_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_reg    <= 1'b0;
            pending_reg <= 2'd0;
        end else begin
            if (job_push) begin
                bank_reg <= ~bank_reg;
            end
            pending_reg <= pending_reg + {1'b0, job_push} - {1'b0, job_release};
        end
    end

endmodule

/* rtl/ss_queue.sv */
// ----------------------------------------------------------------------------
// ss_queue
// Small job FIFO between the intake and the statistics engine.
// ----------------------------------------------------------------------------
module ss_queue import ss_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    job_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   fill_reg;

    assign empty   = (fill_reg == '0);
    assign pop_job = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_reg + {{PTR_W{1'b0}}, push} - {{PTR_W{1'b0}}, pop};
        end
    end

endmodule

/* rtl/ss_div.sv */
// ----------------------------------------------------------------------------
// ss_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ss_div #(
    parameter int DVD_W = 74,
    parameter int DVS_W = 32,
    localparam int CNT_W = $clog2(DVD_W + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output logic             done
);

    logic [DVS_W-1:0] rem_reg, dvs_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [DVS_W:0]   shifted, diff;
    logic             ge;

    assign shifted  = {rem_reg, quo_reg[DVD_W-1]};
    assign ge       = (shifted >= {1'b0, dvs_reg});
    assign diff     = shifted - {1'b0, dvs_reg};
    assign quotient = quo_reg;
    assign done     = done_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

/* rtl/ss_back.sv */
// ----------------------------------------------------------------------------
// ss_back
// Statistics engine: mean and percent change by shared divider, deviation
// pass over the stored series, variance divide, bitwise square root.
// ----------------------------------------------------------------------------
module ss_back import ss_pkg::*; #(
    parameter int MAX_SAMPLES   = DEF_MAX_SAMPLES,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS,
    localparam int IDX_W = $clog2(MAX_SAMPLES),
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1),
    localparam int ACC_W = 2 * SAMPLE_W + IDX_W,
    localparam int DIV_W = ACC_W
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    output logic                q_pop,
    input  job_t                q_job,
    output logic                rd_en,
    output logic [IDX_W:0]      rd_addr,
    input  logic [SAMPLE_W-1:0] rd_data,
    input  logic [THR_W-1:0]    threshold,
    output logic                m_valid,
    input  logic                m_ready,
    output out_item_t           m_data,
    output logic                job_release
);

    back_state_t state_reg, state_next;
    job_t        job_reg;
    out_item_t   out_reg;

    logic signed [SAMPLE_W-1:0] mean_reg, change_reg;
    logic [ACC_W-1:0]           acc_reg;
    logic [CNT_W-1:0]           idx_reg, n;
    logic                       rv_reg, mv_reg, sv_reg;
    logic [SAMPLE_W-1:0]        mag_reg;
    logic [2*SAMPLE_W-1:0]      sq_reg;
    logic                       started_reg;

    logic [2*SAMPLE_W-1:0] x_reg;
    logic [SAMPLE_W+1:0]   r_reg;
    logic [SAMPLE_W-1:0]   q_reg;
    logic [4:0]            step_reg;

    logic             div_start, div_done;
    logic [DIV_W-1:0] div_dvd, div_q;
    logic [31:0]      div_dvs;

    logic                        sum_neg;
    logic [JOB_SUM_W-1:0]        sum_mag;
    logic signed [SAMPLE_W:0]    diff, first_ext, den_full, dev;
    logic [SAMPLE_W-1:0]         diff_mag, den;
    logic [39:0]                 pct_prod;
    logic [63:0]                 pct_dvd;
    logic                        pct_neg, first_zero, pct_big, pass_end;
    logic signed [SAMPLE_W-1:0]  pct_val;
    logic [SAMPLE_W+3:0]         r_try, r_sub, trial;
    logic                        r_ge;
    logic [SAMPLE_W-1:0]         root;
    logic signed [SAMPLE_W:0]    thr_ext, chg_ext;
    trend_t                      trend;

    assign n          = job_reg.count[CNT_W-1:0];
    assign first_zero = (job_reg.first == '0);

    // mean operands
    assign sum_neg = job_reg.sum[JOB_SUM_W-1];
    assign sum_mag = sum_neg ? JOB_SUM_W'(-job_reg.sum) : JOB_SUM_W'(job_reg.sum);

    // percent change operands
    assign diff      = (SAMPLE_W+1)'(job_reg.final_value) - (SAMPLE_W+1)'(job_reg.first);
    assign diff_mag  = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : SAMPLE_W'(diff);
    assign first_ext = (SAMPLE_W+1)'(job_reg.first);
    assign den_full  = job_reg.first[SAMPLE_W-1] ? -first_ext : first_ext;
    assign den       = den_full[SAMPLE_W-1:0];
    assign pct_neg   = diff[SAMPLE_W] != job_reg.first[SAMPLE_W-1];
    assign pct_prod  = 40'(diff_mag) * 40'(PCT_SCALE);
    assign pct_dvd   = 64'(pct_prod) << FRACTION_BITS;
    assign pct_big   = |div_q[DIV_W-1:SAMPLE_W-1];

    always_comb begin
        if (pct_neg) begin
            pct_val = pct_big ? {1'b1, {(SAMPLE_W-1){1'b0}}} : -$signed(div_q[SAMPLE_W-1:0]);
        end else begin
            pct_val = pct_big ? {1'b0, {(SAMPLE_W-1){1'b1}}} : $signed(div_q[SAMPLE_W-1:0]);
        end
    end

    always_comb begin
        case (state_reg)
            ST_MEAN: begin
                div_dvd = DIV_W'(sum_mag);
                div_dvs = 32'(n);
            end
            ST_PCT: begin
                div_dvd = DIV_W'(pct_dvd);
                div_dvs = den;
            end
            default: begin
                div_dvd = acc_reg;
                div_dvs = 32'(n);
            end
        endcase
    end

    ss_div #(
        .DVD_W(DIV_W),
        .DVS_W(32)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quotient (div_q),
        .done     (div_done)
    );

    // deviation pass
    assign dev      = (SAMPLE_W+1)'($signed(rd_data)) - (SAMPLE_W+1)'(mean_reg);
    assign pass_end = (idx_reg == n) && !rv_reg && !mv_reg && !sv_reg;

    // square root step
    assign trial = (SAMPLE_W+4)'({q_reg, 2'b01});
    assign r_try = {r_reg, x_reg[2*SAMPLE_W-1 -: 2]};
    assign r_ge  = (r_try >= trial);
    assign r_sub = r_try - trial;
    assign root  = {q_reg[SAMPLE_W-2:0], r_ge};

    // trend
    assign thr_ext = {2'b00, threshold};
    assign chg_ext = (SAMPLE_W+1)'(change_reg);
    always_comb begin
        if (chg_ext > thr_ext) begin
            trend = TREND_UP;
        end else if (chg_ext < -thr_ext) begin
            trend = TREND_DOWN;
        end else begin
            trend = TREND_FLAT;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (!q_empty) state_next = ST_MEAN;
            ST_MEAN: if (div_done) state_next = ST_PCT;
            ST_PCT:  if (first_zero || div_done) state_next = ST_PASS;
            ST_PASS: if (pass_end) state_next = ST_VAR;
            ST_VAR:  if (div_done) state_next = ST_ROOT;
            ST_ROOT: if (step_reg == '0) state_next = ST_OUT;
            ST_OUT:  if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        q_pop       = 1'b0;
        div_start   = 1'b0;
        rd_en       = 1'b0;
        m_valid     = 1'b0;
        job_release = 1'b0;
        case (state_reg)
            ST_IDLE: q_pop     = !q_empty;
            ST_MEAN: div_start = !started_reg;
            ST_PCT:  div_start = !started_reg && !first_zero;
            ST_PASS: rd_en     = (idx_reg != n);
            ST_VAR:  div_start = !started_reg;
            ST_OUT: begin
                m_valid     = 1'b1;
                job_release = m_ready;
            end
            default: ;
        endcase
    end

    assign rd_addr = {job_reg.bank, idx_reg[IDX_W-1:0]};
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
            rv_reg      <= 1'b0;
            mv_reg      <= 1'b0;
            sv_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (div_done) begin
                started_reg <= 1'b0;
            end else if (div_start) begin
                started_reg <= 1'b1;
            end
            rv_reg <= rd_en;
            mv_reg <= rv_reg;
            sv_reg <= mv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_job;
        end
        case (state_reg)
            ST_MEAN: begin
                if (div_done) begin
                    mean_reg <= sum_neg ? -$signed(div_q[SAMPLE_W-1:0])
                                        : $signed(div_q[SAMPLE_W-1:0]);
                    idx_reg  <= '0;
                    acc_reg  <= '0;
                end
            end
            ST_PCT: begin
                if (first_zero) begin
                    change_reg <= '0;
                end else if (div_done) begin
                    change_reg <= pct_val;
                end
            end
            ST_PASS: begin
                if (rd_en) begin
                    idx_reg <= idx_reg + 1'b1;
                end
                mag_reg <= dev[SAMPLE_W] ? SAMPLE_W'(-dev) : SAMPLE_W'(dev);
                sq_reg  <= mag_reg * mag_reg;
                if (sv_reg) begin
                    acc_reg <= acc_reg + ACC_W'(sq_reg);
                end
            end
            ST_VAR: begin
                if (div_done) begin
                    x_reg    <= div_q[2*SAMPLE_W-1:0];
                    r_reg    <= '0;
                    q_reg    <= '0;
                    step_reg <= 5'd31;
                end
            end
            ST_ROOT: begin
                x_reg    <= {x_reg[2*SAMPLE_W-3:0], 2'b00};
                r_reg    <= r_ge ? r_sub[SAMPLE_W+1:0] : r_try[SAMPLE_W+1:0];
                q_reg    <= root;
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0) begin
                    out_reg.minimum      <= job_reg.minimum;
                    out_reg.maximum      <= job_reg.maximum;
                    out_reg.mean         <= mean_reg;
                    out_reg.change_pct   <= change_reg;
                    out_reg.volatility   <= root;
                    out_reg.trend        <= trend;
                    out_reg.sample_count <= job_reg.count[COUNT_OUT_W-1:0];
                    out_reg.overflowed   <= job_reg.dropped;
                end
            end
            default: ;
        endcase
    end

    a_rd_in_series: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> idx_reg < n)
        else $error("read beyond stored series");

    a_div_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> started_reg)
        else $error("divider result without request");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) && !m_ready |=> (state_reg == ST_OUT) && $stable(out_reg))
        else $error("result changed while stalled");

endmodule

/* rtl/series_statistics.sv */
// ----------------------------------------------------------------------------
// series_statistics
// Min, max, mean, percent change, standard deviation and trend of a series
// of signed fixed-point samples.
// ----------------------------------------------------------------------------
//  channel   dir  signals                     transfer
//  s_        in   s_valid s_ready s_data      one sample, last flag
//  m_        out  m_valid m_ready m_data      one result per series
//  cfg_      in   cfg_valid cfg_ready cfg_data trend threshold write
//
//  Samples are accepted one per cycle while s_ready is high, stored in a
//  two-bank sample RAM. After the last sample the engine runs the mean,
//  percent change and variance divides in the shared one-bit-per-cycle
//  divider, a deviation pass over the RAM read port and a bitwise root.
//  The intake keeps accepting the next series while one is being reduced;
//  it stalls once a second finished series waits. No clearing pass at reset.
// ----------------------------------------------------------------------------
module series_statistics import ss_pkg::*; #(
    parameter int MAX_SAMPLES   = DEF_MAX_SAMPLES,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS,
    localparam int IDX_W = $clog2(MAX_SAMPLES)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [THR_W-1:0] cfg_data
);

    logic [THR_W-1:0]    thr_reg;
    logic                wr_en, rd_en, job_push, job_pop, q_empty, job_release;
    logic [IDX_W:0]      wr_addr, rd_addr;
    logic [SAMPLE_W-1:0] wr_data, rd_data;
    job_t                push_job, pop_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_valid) begin
            thr_reg <= cfg_data;
        end
    end

    ss_front #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .job_push    (job_push),
        .job         (push_job),
        .job_release (job_release)
    );

    ss_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(2 * (1 << IDX_W))
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ss_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (push_job),
        .pop      (job_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    ss_back #(
        .MAX_SAMPLES   (MAX_SAMPLES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_empty),
        .q_pop       (job_pop),
        .q_job       (pop_job),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .threshold   (thr_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .job_release (job_release)
    );

endmodule
